>>> src/kla_pkg.sv
// Shared constants and controller/datapath interface types for the k-th ancestor block.
`timescale 1ns / 1ps

package kla_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 10;
  localparam int NODE_W    = 11;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int JUMP_W    = 20;
  localparam int ADDR_W    = LVL_W + IDX_W;
  localparam int DEPTH     = LEVELS * MAX_NODES;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BROOT,
    ST_BRD1,
    ST_BRD2,
    ST_BWR,
    ST_QSTEP,
    ST_QWAIT,
    ST_QDONE
  } state_t;

  typedef struct packed {
    logic load_store;
    logic q_start;
    logic q_skip;
    logic q_read;
    logic q_take;
    logic b_root;
    logic b_rd1;
    logic b_rd2;
    logic b_wr;
    logic b_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic bit_set;
    logic lvl_end;
    logic nd_last;
    logic lvl_last;
    logic out_free;
  } status_t;

endpackage

>>> src/kth_ancestor_binary_lifting.sv
// Top level of the k-th ancestor block: binary-lifting jump table with load and query items.
`timescale 1ns / 1ps

// Load items store the parent of a node; the load marked last_load starts the table
// build: a root write, then for each level 1..LEVELS-1 a read, a second read and a
// write per node (N nodes, N being node_count clamped to 1..MAX_NODES); it accepts no
// item meanwhile. A query steps through the levels of jumps, ending early when it fails;
// each set bit is a read of the jump table memory whose registered data picks the
// address of the next. Its final state holds while the output register still has an
// unaccepted result. A result waits in an output register while the next item is
// accepted.
module kth_ancestor_binary_lifting
  import kla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [NODE_W-1:0] node,
  input  logic [NODE_W-1:0] parent,
  input  logic [JUMP_W-1:0] jumps,
  input  logic              last_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] ancestor,
  output logic              found
);

  cmd_t    cmd;
  status_t st;

  kla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .last_load (last_load),
    .st        (st),
    .cmd       (cmd)
  );

  kla_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .node        (node),
    .parent      (parent),
    .jumps       (jumps),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ancestor    (ancestor),
    .found       (found),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

>>> src/kla_ctrl.sv
// Controller state machine: sequences loads, the table build and query walks.
`timescale 1ns / 1ps

module kla_ctrl
  import kla_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    operation,
  input  logic    last_load,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (operation == OP_LOAD) begin
            cmd.load_store = 1'b1;
            if (last_load) begin
              state_next = ST_BROOT;
            end
          end else begin
            cmd.q_start = 1'b1;
            state_next  = ST_QSTEP;
          end
        end
      end
      ST_BROOT: begin
        cmd.b_root = 1'b1;
        state_next = ST_BRD1;
      end
      ST_BRD1: begin
        cmd.b_rd1  = 1'b1;
        state_next = ST_BRD2;
      end
      ST_BRD2: begin
        cmd.b_rd2  = 1'b1;
        state_next = ST_BWR;
      end
      ST_BWR: begin
        cmd.b_wr = 1'b1;
        if (st.nd_last && st.lvl_last) begin
          cmd.b_done = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_BRD1;
        end
      end
      ST_QSTEP: begin
        if (!st.ok || st.lvl_end) begin
          state_next = ST_QDONE;
        end else if (st.bit_set) begin
          cmd.q_read = 1'b1;
          state_next = ST_QWAIT;
        end else begin
          cmd.q_skip = 1'b1;
        end
      end
      ST_QWAIT: begin
        cmd.q_take = 1'b1;
        state_next = ST_QSTEP;
      end
      ST_QDONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/kla_datapath.sv
// Datapath: jump table memory, build and query counters, config and result registers.
`timescale 1ns / 1ps

module kla_datapath
  import kla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data,
  input  logic [NODE_W-1:0] node,
  input  logic [NODE_W-1:0] parent,
  input  logic [JUMP_W-1:0] jumps,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] ancestor,
  output logic              found,
  input  cmd_t              cmd,
  output status_t           st
);

  logic [NODE_W-1:0] mem [0:DEPTH-1];

  logic [NODE_W-1:0] node_count;
  logic              built;
  logic [NODE_W-1:0] cur;
  logic [LEVELS-1:0] jbits;
  logic              ok;
  logic [LVL_W-1:0]  lvl;
  logic [NODE_W-1:0] bnd;
  logic              midok;
  logic [NODE_W-1:0] rdata;

  logic [NODE_W-1:0] cnt;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [NODE_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              rdata_ok;
  logic [LVL_W-1:0]  lvl_prev;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] l,
                                                  input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - NODE_W'(1);
    return {l, m[IDX_W-1:0]};
  endfunction

  function automatic logic in_range(input logic [NODE_W-1:0] n,
                                    input logic [NODE_W-1:0] c);
    return (n != '0) && (n <= c);
  endfunction

  always_comb begin
    if (node_count == '0) begin
      cnt = NODE_W'(1);
    end else if (node_count > NODE_W'(MAX_NODES)) begin
      cnt = NODE_W'(MAX_NODES);
    end else begin
      cnt = node_count;
    end
  end

  assign rdata_ok = in_range(rdata, cnt);
  assign lvl_prev = lvl - LVL_W'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.load_store) begin
      wr_en   = (node >= NODE_W'(2)) && (node <= cnt);
      wr_addr = slot_addr('0, node);
      wr_data = in_range(parent, cnt) ? parent : '0;
    end else if (cmd.b_root) begin
      wr_en   = 1'b1;
      wr_addr = slot_addr('0, NODE_W'(1));
      wr_data = '0;
    end else if (cmd.b_wr) begin
      wr_en   = 1'b1;
      wr_addr = slot_addr(lvl, bnd);
      wr_data = midok ? rdata : '0;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.q_read) begin
      rd_en   = 1'b1;
      rd_addr = slot_addr(lvl, cur);
    end else if (cmd.b_rd1) begin
      rd_en   = 1'b1;
      rd_addr = slot_addr(lvl_prev, bnd);
    end else if (cmd.b_rd2) begin
      rd_en   = rdata_ok;
      rd_addr = slot_addr(lvl_prev, rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_W'(1);
      built      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (cfg_wr_en || cmd.load_store) begin
        built <= 1'b0;
      end else if (cmd.b_done) begin
        built <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      cur   <= node;
      jbits <= jumps[LEVELS-1:0];
      ok    <= built && in_range(node, cnt) && (jumps[JUMP_W-1:LEVELS] == '0);
      lvl   <= '0;
    end else if (cmd.q_skip) begin
      jbits <= jbits >> 1;
      lvl   <= lvl + LVL_W'(1);
    end else if (cmd.q_take) begin
      cur   <= rdata;
      ok    <= ok && rdata_ok;
      jbits <= jbits >> 1;
      lvl   <= lvl + LVL_W'(1);
    end else if (cmd.b_root) begin
      lvl <= LVL_W'(1);
      bnd <= NODE_W'(1);
    end else if (cmd.b_rd2) begin
      midok <= rdata_ok;
    end else if (cmd.b_wr) begin
      if (bnd == cnt) begin
        bnd <= NODE_W'(1);
        lvl <= lvl + LVL_W'(1);
      end else begin
        bnd <= bnd + NODE_W'(1);
      end
    end
    if (cmd.out_load) begin
      ancestor <= ok ? cur : '0;
      found    <= ok;
    end
  end

  assign st.ok       = ok;
  assign st.bit_set  = jbits[0];
  assign st.lvl_end  = (lvl == LVL_W'(LEVELS));
  assign st.nd_last  = (bnd == cnt);
  assign st.lvl_last = (lvl == LVL_W'(LEVELS - 1));
  assign st.out_free = !out_valid || out_ready;

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> ancestor == '0)
    else $error("not-found result carries a nonzero ancestor");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && ok |-> cur != '0 && cur <= cnt)
    else $error("found ancestor outside the loaded tree");

  a_build_sets: assert property (@(posedge clk) disable iff (rst)
    cmd.b_done |=> built)
    else $error("table not marked built after build");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load_store |=> !built)
    else $error("table still marked built after a load");

endmodule
